/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL of the positional array.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PIDA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define PIDA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/pida_pkg.sv */
// Package with the transaction types, codes and cell controls of the positional array.
`timescale 1ns / 1ps

package pida_pkg;

  localparam int CMD_W      = 3;
  localparam int POS_W      = 7;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 6;
  localparam int ENTRIES_W  = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] element;
    logic [SLOT_W-1:0]         slot;
    logic [ENTRIES_W-1:0]      entries;
    logic                      last;
  } res_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tap_en;
  } cell_ctl_t;

endpackage

/* hw/rtl/pida_cell.sv */
// One storage cell of the array chain with its shift, load and rotate selection.
`timescale 1ns / 1ps

module pida_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  pida_pkg::cell_ctl_t   ctl,
  input  logic [CNT_W-1:0]      pidx,
  input  logic [CNT_W-1:0]      tail,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  logic [DATA_WIDTH-1:0] head_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tap
);

  localparam logic [CNT_W-1:0] ME = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      pida_pkg::CELL_INSERT: begin
        if (ME == pidx) begin
          data_next = value;
        end else if (ME > pidx) begin
          data_next = prev_data;
        end
      end
      pida_pkg::CELL_DELETE: begin
        if (ME >= pidx) begin
          data_next = next_data;
        end
      end
      pida_pkg::CELL_ROTATE: begin
        if (ME == tail) begin
          data_next = head_data;
        end else if (ME < tail) begin
          data_next = next_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Only the addressed cell shows its word on the tap, so the taps can be ORed.
  assign tap = (ctl.tap_en && (ME == pidx)) ? data : '0;

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* hw/rtl/positional_insert_delete_array.sv */
// An edit transaction's status result is valid in the cycle after the accepting edge; the
// first entry of a list is registered in the list state that the accepting edge enters.
// Throughput, while results are taken: one edit per cycle; a list of n entries streams n
// results at one per cycle, paced by the chain's single rotation step; the next command waits.
// Reset (synchronous, active high) empties the array and drops any pending result; the cell
// words are not cleared, since no entry at or above the count is ever read.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module positional_insert_delete_array #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  pida_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output pida_pkg::res_t res
);

  // The count can reach DEPTH itself, so it gets one state more than an index.
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Compare width covers both the 7-bit position field and the count, plus a carry bit.
  localparam int CMP_W = ((CNT_W > pida_pkg::POS_W) ? CNT_W : pida_pkg::POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] lidx;
  logic [CNT_W-1:0] lidx_next;
  logic             res_valid_next;
  pida_pkg::res_t   res_next;
  logic             load_res;

  // Cell chain signals.
  logic [DATA_WIDTH-1:0] cell_q   [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap [DEPTH];
  pida_pkg::cell_ctl_t   ctl;
  logic [CNT_W-1:0]      pidx;
  logic [CNT_W-1:0]      tail;
  logic [DATA_WIDTH-1:0] value_dw;
  logic [DATA_WIDTH-1:0] gone;

  // Decode helpers.
  logic                  cmd_fire;
  logic                  out_free;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      cnt_next_ext;
  logic [CMP_W-1:0]      lidx_ext;
  logic [CNT_W-1:0]      pos_m1;
  logic                  is_full;
  logic                  is_empty;
  logic                  ins_bad;
  logic                  del_bad;
  logic                  list_last;
  logic [63:0]           value_sx;
  logic [63:0]           elem_wide;
  logic [DATA_WIDTH-1:0] elem_src;

  // The result register parts the two sides: a new command is taken whenever the
  // register is empty or is being drained in the same cycle.
  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign pos_ext  = CMP_W'(cmd.position);
  assign cnt_ext  = CMP_W'(count);
  assign lidx_ext = CMP_W'(lidx);
  assign pos_m1   = CNT_W'(pos_ext - CMP_W'(1));
  assign tail     = count - CNT_W'(1);
  assign is_full  = cnt_ext >= CMP_W'(DEPTH);
  assign is_empty = (count == '0);
  // Insert may go one past the last entry; delete must name an existing entry.
  assign ins_bad  = (pos_ext == '0) || (pos_ext > (cnt_ext + CMP_W'(1)));
  assign del_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign list_last = (lidx == tail);

  // The value is sign-extended and then kept in the low DATA_WIDTH bits.
  assign value_sx = {{(64 - pida_pkg::VALUE_W){cmd.value[pida_pkg::VALUE_W-1]}}, cmd.value};
  assign value_dw = value_sx[DATA_WIDTH-1:0];

  // The removed word comes from the one tapped cell.
  always_comb begin
    gone = '0;
    for (int g = 0; g < DEPTH; g++) begin
      gone = gone | cell_tap[g];
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    lidx_next  = lidx;
    load_res   = 1'b0;
    ctl.op     = pida_pkg::CELL_HOLD;
    ctl.tap_en = 1'b0;
    pidx       = pos_m1;
    elem_src   = '0;
    res_next.status  = pida_pkg::STAT_OK;
    res_next.slot    = '0;
    res_next.last    = 1'b1;

    priority if (state == S_LIST) begin
      // Listing rotates the stored entries through cell zero, one per cycle while results
      // are taken, so the order is back in place once the last entry has gone out.
      if (out_free) begin
        load_res      = 1'b1;
        ctl.op        = pida_pkg::CELL_ROTATE;
        elem_src      = cell_q[0];
        res_next.slot = lidx_ext[pida_pkg::SLOT_W-1:0];
        res_next.last = list_last;
        if (list_last) begin
          state_next = S_IDLE;
        end else begin
          lidx_next = lidx + CNT_W'(1);
        end
      end
    end else if (cmd_fire) begin
      unique case (cmd.command)
        pida_pkg::CMD_CLEAR: begin
          load_res   = 1'b1;
          count_next = '0;
        end
        pida_pkg::CMD_APPEND: begin
          load_res = 1'b1;
          if (is_full) begin
            res_next.status = pida_pkg::STAT_FULL;
          end else begin
            // An append is an insert just past the last entry.
            ctl.op     = pida_pkg::CELL_INSERT;
            pidx       = count;
            count_next = count + CNT_W'(1);
          end
        end
        pida_pkg::CMD_INSERT: begin
          load_res = 1'b1;
          if (ins_bad) begin
            res_next.status = pida_pkg::STAT_BAD_POS;
          end else if (is_full) begin
            res_next.status = pida_pkg::STAT_FULL;
          end else begin
            ctl.op     = pida_pkg::CELL_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
        pida_pkg::CMD_DELETE: begin
          load_res = 1'b1;
          if (is_empty) begin
            res_next.status = pida_pkg::STAT_EMPTY;
          end else if (del_bad) begin
            res_next.status = pida_pkg::STAT_BAD_POS;
          end else begin
            ctl.op     = pida_pkg::CELL_DELETE;
            ctl.tap_en = 1'b1;
            elem_src   = gone;
            count_next = count - CNT_W'(1);
          end
        end
        pida_pkg::CMD_LIST: begin
          if (is_empty) begin
            load_res        = 1'b1;
            res_next.status = pida_pkg::STAT_EMPTY;
          end else begin
            state_next = S_LIST;
            lidx_next  = '0;
          end
        end
        default: begin
          // Unused command codes are taken and dropped without a result.
          load_res = 1'b0;
        end
      endcase
    end

    // The word and the entry count are zero-extended or cut to the field widths.
    elem_wide        = 64'(elem_src);
    cnt_next_ext     = CMP_W'(count_next);
    res_next.element = elem_wide[pida_pkg::VALUE_W-1:0];
    res_next.entries = cnt_next_ext[pida_pkg::ENTRIES_W-1:0];
  end

  always_comb begin
    if (load_res) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      lidx      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      lidx      <= lidx_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= res_next;
    end
  end

  // The chain: every cell sees its neighbors (zero past either end) and the head of the chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data;
    logic [DATA_WIDTH-1:0] next_data;

    if (g == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_prev
      assign prev_data = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_final
      assign next_data = '0;
    end else begin : g_next
      assign next_data = cell_q[g+1];
    end

    pida_cell #(
      .INDEX      (g),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pidx      (pidx),
      .tail      (tail),
      .value     (value_dw),
      .prev_data (prev_data),
      .next_data (next_data),
      .head_data (cell_q[0]),
      .data      (cell_q[g]),
      .tap       (cell_tap[g])
    );
  end

  `PIDA_ASSERT(a_clear_empties, clk, rst,
    (cmd_fire && (cmd.command == pida_pkg::CMD_CLEAR)) |=> (count == '0),
    "clear transaction did not empty the array")
  `PIDA_ASSERT(a_count_stable_idle, clk, rst,
    !cmd_fire |=> $stable(count),
    "entry count changed without an accepted transaction")
  `PIDA_ASSERT(a_list_ends_marked, clk, rst,
    ((state == S_LIST) && out_free && list_last) |=>
      ((state == S_IDLE) && res_valid && res.last),
    "listing did not end with a marked final result")
  `PIDA_ASSERT(a_count_bounded, clk, rst,
    (CMP_W'(count) <= CMP_W'(DEPTH)),
    "entry count exceeds the array depth")
  `PIDA_ASSERT_ALWAYS(a_reset_drops_result, clk,
    rst |=> !res_valid,
    "result still valid after reset")

endmodule
